[design/ptw_pkg.sv]
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants of the page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

  localparam int unsigned Levels     = 4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_ORDER = 2'd2,
    ST_PTR   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_ROOT   = 2'd0,
    REG_POOL   = 2'd1,
    REG_LEVELS = 2'd2
  } reg_idx_t;

  typedef enum logic {
    MODE_MAP   = 1'b0,
    MODE_UNMAP = 1'b1
  } mode_t;

endpackage

`default_nettype wire

[design/ptw_ram.sv]
// ----------------------------------------------------------------------------
// ptw_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

[design/page_table_map_unmap_walker.sv]
// ----------------------------------------------------------------------------
// page_table_map_unmap_walker
// Maps or unmaps runs of pages in a four-level radix page table.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one request beat: mode, vaddr,
// paddr, order_log2, page_count, attributes. Output channel (out_valid /
// out_stall) returns one beat per request: status and pages_done.
// Configuration beats (cfg_valid / cfg_ready, cfg_index, cfg_data) set the
// root base, pool base and number of levels; write them while idle.
// Every table access goes through one single-port RAM with registered read
// data, so each intermediate level takes a read state (S_WALK) and a decode
// state (S_READ), and each leaf a single write in S_WALK; a bad order or an
// empty run goes straight to S_FIN without touching the table.
// After reset the table RAM is swept to zero, one entry per cycle, over all
// (POOL_PAGES + 1) * 512 entries; in_stall stays high meanwhile.
// The result sits in an output register; while out_stall holds it, the
// block still accepts the next request and waits only to post its result.
// ----------------------------------------------------------------------------
`default_nettype none

module page_table_map_unmap_walker
  import ptw_pkg::*;
#(
  parameter int unsigned POOL_PAGES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [47:0] vaddr,
  input  wire logic [47:0] paddr,
  input  wire logic [5:0]  order_log2,
  input  wire logic [15:0] page_count,
  input  wire logic [63:0] attributes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [15:0]      pages_done
);

  localparam int unsigned DEPTH = (POOL_PAGES + 1) * 512;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(POOL_PAGES + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WALK, S_READ, S_FIN
  } state_t;

  state_t state;

  logic [47:0] root_base, pool_base;
  logic [2:0]  levels;

  logic          mode_r;
  logic [47:0]   va;
  logic [55:0]   pa;
  logic [63:0]   attr;
  logic [5:0]    order;
  logic [15:0]   count, idx_i, done;
  logic [1:0]    lvl, start_lvl, target_lvl;
  logic [PW-1:0] page, alloc_cnt;
  logic [AW-1:0] clr_addr;
  status_t       res_status;

  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [63:0]   ram_wdata, ram_rdata;

  logic [8:0]    idx;
  logic [AW-1:0] ent_addr;
  logic [63:0]   ps, ptr, diff, alloc_val;
  logic          in_pool, is_root, last_page, pool_full;
  logic [2:0]    lv_c;
  logic [1:0]    start_c, target_c;
  logic          order_ok;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    case (lvl)
      2'd0:    idx = va[39 +: 9];
      2'd1:    idx = va[30 +: 9];
      2'd2:    idx = va[21 +: 9];
      default: idx = va[12 +: 9];
    endcase
  end

  assign ent_addr  = {page, idx};
  assign ps        = {16'd0, pool_base[47:12], 12'd0};
  assign ptr       = ram_rdata & ~64'd3;
  assign diff      = ptr - ps;
  assign in_pool   = (ptr >= ps) && (diff[63:12] < 52'(POOL_PAGES));
  assign is_root   = (ptr[63:12] == {16'd0, root_base[47:12]});
  assign alloc_val = (ps + {{(52-PW){1'b0}}, alloc_cnt, 12'd0}) | 64'd3;
  assign last_page = ((idx_i + 16'd1) == count);
  assign pool_full = (alloc_cnt == PW'(POOL_PAGES));

  always_comb begin
    lv_c = levels;
    if (levels == 3'd0) lv_c = 3'd1;
    if (levels > 3'd4)  lv_c = 3'd4;
    start_c = 2'(3'd4 - lv_c);
    order_ok = 1'b1;
    case (order_log2)
      6'd39:   target_c = 2'd0;
      6'd30:   target_c = 2'd1;
      6'd21:   target_c = 2'd2;
      6'd12:   target_c = 2'd3;
      default: begin
        target_c = 2'd0;
        order_ok = 1'b0;
      end
    endcase
    if (target_c < start_c) order_ok = 1'b0;
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = ent_addr;
    ram_wdata = 64'd0;
    case (state)
      S_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      S_WALK: begin
        ram_en = 1'b1;
        if (lvl == target_lvl) begin
          ram_we    = 1'b1;
          ram_wdata = (mode_r == MODE_MAP) ? ({8'd0, pa} | attr) : 64'd0;
        end
      end
      S_READ: begin
        if (ram_rdata == 64'd0 && mode_r == MODE_MAP && !pool_full) begin
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = alloc_val;
        end
      end
      default: ;
    endcase
  end

  ptw_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      alloc_cnt <= '0;
      out_valid <= 1'b0;
      root_base <= 48'd0;
      pool_base <= 48'd4096;
      levels    <= 3'd4;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROOT:   root_base <= cfg_data;
          REG_POOL:   pool_base <= cfg_data;
          REG_LEVELS: levels    <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (state == S_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            mode_r     <= mode;
            va         <= vaddr;
            pa         <= {8'd0, paddr};
            attr       <= attributes;
            order      <= order_log2;
            count      <= page_count;
            idx_i      <= 16'd0;
            done       <= 16'd0;
            start_lvl  <= start_c;
            target_lvl <= target_c;
            lvl        <= start_c;
            page       <= '0;
            res_status <= order_ok ? ST_OK : ST_ORDER;
            state      <= (order_ok && page_count != 16'd0) ? S_WALK : S_FIN;
          end
        end
        S_WALK: begin
          if (lvl == target_lvl) begin
            done <= done + 16'd1;
            if (last_page) begin
              state <= S_FIN;
            end else begin
              idx_i <= idx_i + 16'd1;
              va    <= va + (48'd1 << order);
              pa    <= pa + (56'd1 << order);
              lvl   <= start_lvl;
              page  <= '0;
            end
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_WALK;
          if (ram_rdata == 64'd0) begin
            if (mode_r == MODE_UNMAP) begin
              if (last_page) begin
                state <= S_FIN;
              end else begin
                idx_i <= idx_i + 16'd1;
                va    <= va + (48'd1 << order);
                lvl   <= start_lvl;
                page  <= '0;
              end
            end else if (pool_full) begin
              res_status <= ST_OOM;
              state      <= S_FIN;
            end else begin
              alloc_cnt <= alloc_cnt + PW'(1);
              page      <= alloc_cnt + PW'(1);
              lvl       <= lvl + 2'd1;
            end
          end else if (in_pool) begin
            page <= diff[12 +: PW] + PW'(1);
            lvl  <= lvl + 2'd1;
          end else if (is_root) begin
            page <= '0;
            lvl  <= lvl + 2'd1;
          end else begin
            res_status <= ST_PTR;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            status     <= res_status;
            pages_done <= done;
            state      <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef SYNTH
  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    alloc_cnt <= PW'(POOL_PAGES))
    else $error("allocator count beyond pool");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FIN) |-> !ram_we)
    else $error("table write outside a walk");

  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (done <= count))
    else $error("more pages done than requested");

  a_result_post: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !out_valid) |=> out_valid)
    else $error("finished result not posted");
`endif

endmodule

`default_nettype wire
